// ----- sv/kctm_pkg.sv -----
// ----------------------------------------------------------------------------
// kctm_pkg
// Shared codes, limits and controller/datapath interface types for the
// key chord trigger matcher.
// ----------------------------------------------------------------------------
package kctm_pkg;

    // operation codes of a request
    localparam logic [2:0] OP_LOAD_REQ  = 3'd0;
    localparam logic [2:0] OP_LOAD_TRIG = 3'd1;
    localparam logic [2:0] OP_PRESS     = 3'd2;
    localparam logic [2:0] OP_RELEASE   = 3'd3;
    localparam logic [2:0] OP_TICK      = 3'd4;

    // key status codes
    localparam logic [1:0] ST_RELEASED = 2'd0;
    localparam logic [1:0] ST_JUST     = 2'd1;
    localparam logic [1:0] ST_HELD     = 2'd2;

    // fixed field widths
    localparam int OP_W     = 3;
    localparam int SLOT_W   = 6;
    localparam int TIX_W    = 4;
    localparam int KEY_W    = 16;
    localparam int ACT_W    = 16;
    localparam int GRP_W    = 8;
    localparam int STAT_W   = 2;

    // at most this many results per frame tick
    localparam int RESULT_LIMIT = 16;
    localparam int CNT_W        = 5;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic start;   // request taken this cycle
        logic scan;    // read the next requirement slot
        logic emit;    // evaluate the current trigger
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_last;  // reading the final requirement slot
        logic emit_done;  // current trigger is the final one of the tick
        logic is_tick;    // request in work is a frame tick
    } t_sts;

endpackage

// ----- sv/key_chord_trigger_matcher.sv -----
// ----------------------------------------------------------------------------
// key_chord_trigger_matcher
// Matches key presses and releases against a table of key requirements and
// emits the actions of satisfied triggers on each frame tick.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low; the
//   operation field selects load requirement, load trigger, key press, key
//   release or frame tick. Unused operation codes are taken and dropped.
//   Loads finish in the cycle they are taken; busy stays low.
//   Press and release walk the requirement memory one slot a cycle through
//   its read port and its write port; busy stays high for the walk.
//   A frame tick walks the requirement memory the same way to collect a
//   fail bit per trigger, then walks the triggers one a cycle, stopping at
//   the last met trigger or at the 16th result; busy stays high throughout.
//   Each result is shown for one cycle with o_strobe high, in the cycle after
//   its trigger is evaluated; o_last_of_tick marks the final one. A tick with
//   no met trigger gives one empty result. The receiver cannot stall.
//   Reset clears all requirement and trigger valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module key_chord_trigger_matcher #(
    parameter int MAX_REQUIREMENTS = 64,
    parameter int MAX_TRIGGERS     = 16,
    parameter int KEY_BITS         = 16,
    parameter int ACTION_BITS      = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [kctm_pkg::OP_W-1:0]         i_operation,
    input  logic [kctm_pkg::SLOT_W-1:0]       i_slot,
    input  logic [kctm_pkg::TIX_W-1:0]        i_trigger_index,
    input  logic [kctm_pkg::KEY_W-1:0]        i_key_code,
    input  logic                              i_need_fresh,
    input  logic [kctm_pkg::ACT_W-1:0]        i_action_id,
    input  logic [kctm_pkg::GRP_W-1:0]        i_action_group,
    input  logic                              i_enable,
    output logic                              o_strobe,
    output logic                              o_has_action,
    output logic [kctm_pkg::ACT_W-1:0]        o_action_id_res,
    output logic [kctm_pkg::GRP_W-1:0]        o_action_group_res,
    output logic                              o_last_of_tick
);

    kctm_pkg::t_cmd w_cmd;
    kctm_pkg::t_sts w_sts;

    // sequencer
    kctm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .busy        (busy)
    );

    // tables and result path
    kctm_dp #(
        .MAX_REQUIREMENTS (MAX_REQUIREMENTS),
        .MAX_TRIGGERS     (MAX_TRIGGERS),
        .KEY_BITS         (KEY_BITS),
        .ACTION_BITS      (ACTION_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_operation        (i_operation),
        .i_slot             (i_slot),
        .i_trigger_index    (i_trigger_index),
        .i_key_code         (i_key_code),
        .i_need_fresh       (i_need_fresh),
        .i_action_id        (i_action_id),
        .i_action_group     (i_action_group),
        .i_enable           (i_enable),
        .o_strobe           (o_strobe),
        .o_has_action       (o_has_action),
        .o_action_id_res    (o_action_id_res),
        .o_action_group_res (o_action_group_res),
        .o_last_of_tick     (o_last_of_tick)
    );

    // loads and unused codes never hold the block busy
    a_load_single_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation != kctm_pkg::OP_PRESS &&
         i_operation != kctm_pkg::OP_RELEASE && i_operation != kctm_pkg::OP_TICK)
        |=> !busy)
        else $error("load request left the block busy");

    // an empty tick result is always the last of its tick
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_has_action) |-> o_last_of_tick)
        else $error("empty tick result without last flag");

    // results come only from a frame tick
    a_result_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> w_sts.is_tick)
        else $error("result strobe outside a frame tick");

endmodule

// ----- sv/kctm_ctrl.sv -----
// ----------------------------------------------------------------------------
// kctm_ctrl
// Sequencer: takes a request, walks the requirement table for key events
// and ticks, then walks the triggers to emit the tick results.
// ----------------------------------------------------------------------------
module kctm_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic [kctm_pkg::OP_W-1:0]        i_operation,
    input  kctm_pkg::t_sts                   i_sts,
    output kctm_pkg::t_cmd                   o_cmd,
    output logic                             busy
);

    kctm_pkg::t_state r_state;
    kctm_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kctm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        busy      = 1'b1;
        unique case (r_state)
            kctm_pkg::S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.start = 1'b1;
                    if (i_operation == kctm_pkg::OP_PRESS ||
                        i_operation == kctm_pkg::OP_RELEASE ||
                        i_operation == kctm_pkg::OP_TICK) begin
                        n_state = kctm_pkg::S_SCAN;
                    end
                end
            end
            kctm_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = kctm_pkg::S_DRAIN;
                end
            end
            kctm_pkg::S_DRAIN: begin
                // last read slot is updated in this cycle
                n_state = i_sts.is_tick ? kctm_pkg::S_EMIT : kctm_pkg::S_IDLE;
            end
            kctm_pkg::S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_sts.emit_done) begin
                    n_state = kctm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kctm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/kctm_dp.sv -----
// ----------------------------------------------------------------------------
// kctm_dp
// Datapath: requirement memory with read-modify-write scan, trigger table,
// per-trigger fail vector and registered result outputs.
// ----------------------------------------------------------------------------
module kctm_dp #(
    parameter int MAX_REQUIREMENTS = 64,
    parameter int MAX_TRIGGERS     = 16,
    parameter int KEY_BITS         = 16,
    parameter int ACTION_BITS      = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  kctm_pkg::t_cmd                    i_cmd,
    output kctm_pkg::t_sts                    o_sts,
    input  logic [kctm_pkg::OP_W-1:0]         i_operation,
    input  logic [kctm_pkg::SLOT_W-1:0]       i_slot,
    input  logic [kctm_pkg::TIX_W-1:0]        i_trigger_index,
    input  logic [kctm_pkg::KEY_W-1:0]        i_key_code,
    input  logic                              i_need_fresh,
    input  logic [kctm_pkg::ACT_W-1:0]        i_action_id,
    input  logic [kctm_pkg::GRP_W-1:0]        i_action_group,
    input  logic                              i_enable,
    output logic                              o_strobe,
    output logic                              o_has_action,
    output logic [kctm_pkg::ACT_W-1:0]        o_action_id_res,
    output logic [kctm_pkg::GRP_W-1:0]        o_action_group_res,
    output logic                              o_last_of_tick
);

    localparam int RW   = (MAX_REQUIREMENTS > 1) ? $clog2(MAX_REQUIREMENTS) : 1;
    localparam int TW   = (MAX_TRIGGERS > 1) ? $clog2(MAX_TRIGGERS) : 1;
    localparam int KW   = (KEY_BITS < kctm_pkg::KEY_W) ? KEY_BITS : kctm_pkg::KEY_W;
    localparam int AW   = (ACTION_BITS < kctm_pkg::ACT_W) ? ACTION_BITS : kctm_pkg::ACT_W;
    // memory word: key, need fresh, owner, status
    localparam int MW   = KW + 1 + kctm_pkg::TIX_W + kctm_pkg::STAT_W;
    localparam logic [RW-1:0] REQ_LAST  = RW'(MAX_REQUIREMENTS - 1);
    localparam logic [TW-1:0] TRIG_LAST = TW'(MAX_TRIGGERS - 1);

    // requirement memory and its valid bits
    logic [MW-1:0]               r_mem [MAX_REQUIREMENTS];
    logic [MW-1:0]               r_rd_data;
    logic [MAX_REQUIREMENTS-1:0] r_req_valid;

    // trigger table
    logic [MAX_TRIGGERS-1:0]          r_trig_valid;
    logic [AW-1:0]                    r_trig_action [MAX_TRIGGERS];
    logic [kctm_pkg::GRP_W-1:0]       r_trig_group  [MAX_TRIGGERS];

    // request context and walk counters
    logic [kctm_pkg::OP_W-1:0]  r_op;
    logic [KW-1:0]              r_key;
    logic [RW-1:0]              r_rd_idx;
    logic [RW-1:0]              r_wr_idx;
    logic                       r_rd_vld;
    logic [MAX_TRIGGERS-1:0]    r_fail;
    logic [TW-1:0]              r_tidx;
    logic [kctm_pkg::CNT_W-1:0] r_cnt;

    // decoded fields
    logic [31:0]                slot_ext;
    logic [31:0]                tix_ext;
    logic [31:0]                owner_ext;
    logic                       load_req;
    logic                       load_trig;
    logic [KW-1:0]              rd_key;
    logic                       rd_fresh;
    logic [kctm_pkg::TIX_W-1:0] rd_owner;
    logic [kctm_pkg::STAT_W-1:0] rd_stat;
    logic                       rd_match;
    logic                       rd_met;
    logic                       mem_we;
    logic [RW-1:0]              mem_waddr;
    logic [MW-1:0]              mem_wdata;
    logic [kctm_pkg::STAT_W-1:0] new_stat;
    logic [MAX_TRIGGERS-1:0]    met;
    logic [MAX_TRIGGERS-1:0]    met_above;
    logic                       cur_met;
    logic                       cur_last;

    assign slot_ext  = 32'(i_slot);
    assign tix_ext   = 32'(i_trigger_index);
    assign load_req  = i_cmd.start && (i_operation == kctm_pkg::OP_LOAD_REQ) &&
                       (slot_ext < 32'(MAX_REQUIREMENTS)) && (tix_ext < 32'(MAX_TRIGGERS));
    assign load_trig = i_cmd.start && (i_operation == kctm_pkg::OP_LOAD_TRIG) &&
                       (tix_ext < 32'(MAX_TRIGGERS));

    // unpack the registered memory word
    assign {rd_key, rd_fresh, rd_owner, rd_stat} = r_rd_data;
    assign owner_ext = 32'(rd_owner);
    assign rd_match  = r_req_valid[r_wr_idx] && (rd_key == r_key);
    assign rd_met    = rd_fresh ? (rd_stat == kctm_pkg::ST_JUST)
                                : (rd_stat == kctm_pkg::ST_JUST ||
                                   rd_stat == kctm_pkg::ST_HELD);

    // memory write: load, or status update during a key event scan
    always_comb begin
        new_stat  = kctm_pkg::ST_RELEASED;
        mem_we    = 1'b0;
        mem_waddr = r_wr_idx;
        mem_wdata = r_rd_data;
        if (load_req) begin
            mem_we    = 1'b1;
            mem_waddr = slot_ext[RW-1:0];
            mem_wdata = {i_key_code[KW-1:0], i_need_fresh, i_trigger_index,
                         kctm_pkg::ST_RELEASED};
        end else if (r_rd_vld && rd_match &&
                     (r_op == kctm_pkg::OP_PRESS || r_op == kctm_pkg::OP_RELEASE)) begin
            if (r_op == kctm_pkg::OP_PRESS) begin
                new_stat = (rd_stat == kctm_pkg::ST_RELEASED) ? kctm_pkg::ST_JUST
                                                               : kctm_pkg::ST_HELD;
            end
            mem_we    = 1'b1;
            mem_wdata = {rd_key, rd_fresh, rd_owner, new_stat};
        end
    end

    // requirement memory ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[r_rd_idx];
    end

    // valid bits and trigger table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid  <= '0;
            r_trig_valid <= '0;
        end else begin
            if (load_req) begin
                r_req_valid[slot_ext[RW-1:0]] <= i_enable;
            end
            if (load_trig) begin
                r_trig_valid[tix_ext[TW-1:0]] <= i_enable;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_trig) begin
            r_trig_action[tix_ext[TW-1:0]] <= i_action_id[AW-1:0];
            r_trig_group[tix_ext[TW-1:0]]  <= i_action_group;
        end
    end

    // request context, scan pipeline and fail vector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op     <= kctm_pkg::OP_LOAD_REQ;
            r_rd_vld <= 1'b0;
            r_rd_idx <= '0;
            r_wr_idx <= '0;
            r_fail   <= '0;
            r_tidx   <= '0;
            r_cnt    <= '0;
            r_key    <= '0;
        end else begin
            r_rd_vld <= i_cmd.scan;
            if (i_cmd.start) begin
                r_op     <= i_operation;
                r_key    <= i_key_code[KW-1:0];
                r_rd_idx <= '0;
                r_fail   <= '0;
                r_tidx   <= '0;
                r_cnt    <= '0;
            end
            if (i_cmd.scan) begin
                r_wr_idx <= r_rd_idx;
                r_rd_idx <= r_rd_idx + RW'(1);
            end
            if (r_rd_vld && r_op == kctm_pkg::OP_TICK && r_req_valid[r_wr_idx] &&
                owner_ext < 32'(MAX_TRIGGERS) && !rd_met) begin
                r_fail[owner_ext[TW-1:0]] <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_tidx <= r_tidx + TW'(1);
                if (cur_met) begin
                    r_cnt <= r_cnt + kctm_pkg::CNT_W'(1);
                end
            end
        end
    end

    // met triggers and the ones still to come after the current one
    assign met     = r_trig_valid & ~r_fail;
    assign cur_met = met[r_tidx];
    always_comb begin
        for (int i = 0; i < MAX_TRIGGERS; i++) begin
            met_above[i] = met[i] && (32'(i) > 32'(r_tidx));
        end
    end
    assign cur_last = (met_above == '0) ||
                      (r_cnt == kctm_pkg::CNT_W'(kctm_pkg::RESULT_LIMIT - 1));

    // status to the controller
    always_comb begin
        o_sts.scan_last = (r_rd_idx == REQ_LAST);
        o_sts.is_tick   = (r_op == kctm_pkg::OP_TICK);
        o_sts.emit_done = (met == '0) || (r_tidx == TRIG_LAST) || (cur_met && cur_last);
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= i_cmd.emit && ((met == '0) || cur_met);
        end
    end

    always_ff @(posedge i_clk) begin
        if (met == '0) begin
            o_has_action       <= 1'b0;
            o_action_id_res    <= '0;
            o_action_group_res <= '0;
            o_last_of_tick     <= 1'b1;
        end else begin
            o_has_action       <= 1'b1;
            o_action_id_res    <= kctm_pkg::ACT_W'(r_trig_action[r_tidx]);
            o_action_group_res <= r_trig_group[r_tidx];
            o_last_of_tick     <= cur_last;
        end
    end

endmodule
